// ===== design/counter_priority_task_scheduler_unit_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Each macro checks a property on clk with arst_n as its disable condition.
// -----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");
`define CPTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");
`else
`define CPTS_ASSERT_NOW(lbl, ante, cons)
`define CPTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/cpts_pkg.sv =====
// -----------------------------------------------------------------------------
// cpts_pkg
// Types, constants and helpers shared by the task scheduler modules.
// -----------------------------------------------------------------------------
`default_nettype none
package cpts_pkg;
	localparam int TASK_SLOTS = 64;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int IDX_W      = SLOT_W + 1;
	localparam int CNT_W      = 9;
	localparam int PRIO_W     = 8;
	localparam int DEPTH_W    = 8;
	localparam int REAP_W     = 7;

	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_YIELD   = 3'd1;
	localparam logic [2:0] CMD_EXIT    = 3'd2;
	localparam logic [2:0] CMD_REAP    = 3'd3;
	localparam logic [2:0] CMD_PDIS    = 3'd4;
	localparam logic [2:0] CMD_PEN     = 3'd5;
	localparam logic [2:0] CMD_INSTALL = 3'd6;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	typedef struct packed {
		logic [CNT_W-1:0]   counter;
		logic [PRIO_W-1:0]  prio;
		logic [DEPTH_W-1:0] depth;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            data;
	} ram_wr_t;

	// An entry never written reads as all zero; slot zero takes its priority
	// from the configuration register while that register owns it.
	function automatic entry_t entry_view(entry_t raw, logic written, logic use_cfg,
			logic [PRIO_W-1:0] cfg_prio);
		entry_t e;
		e = written ? raw : '0;
		if (use_cfg) begin
			e.prio = cfg_prio;
		end
		return e;
	endfunction
endpackage
`default_nettype wire

// ===== design/counter_priority_task_scheduler_unit.sv =====
// -----------------------------------------------------------------------------
// counter_priority_task_scheduler_unit
// Counter and priority based task scheduler over a table of task slots.
// -----------------------------------------------------------------------------
// Commands arrive on the in channel (valid/ready); each one produces exactly
// one result transfer on the out channel (valid/ready) holding the current
// and previous slot, a switch flag, the reap count and the fallback status.
// The cfg channel writes the initial priority of slot zero; it is always
// ready and must only be used while no command is in flight.
// One command is worked on at a time. Install and unused codes go straight
// to the result; preempt commands and ticks without a reschedule first pass
// through a read-modify-write of the running slot's entry, and a reap sweeps
// the slot flags one slot a cycle. A reschedule scans the table memory one
// slot a cycle, then selects; when the best counter found is zero and a
// runnable slot has a nonzero priority, a second read-modify-write pass
// recharges every valid slot's counter.
// The result sits in an output register; a new command is taken from the
// cycle after that register is loaded, and a stalled receiver only holds the
// block when the next result is ready to be loaded.
// Reset makes slot zero the only valid task and the one running, and clears
// all other table state at once through per-slot written flags.
// -----------------------------------------------------------------------------
`default_nettype none
`include "counter_priority_task_scheduler_unit_macros.svh"
module counter_priority_task_scheduler_unit import cpts_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         command,
	input  wire logic [SLOT_W-1:0]  slot,
	input  wire logic [PRIO_W-1:0]  priority_req,
	input  wire logic [CNT_W-1:0]   counter_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [SLOT_W-1:0]       current_slot,
	output logic [SLOT_W-1:0]       previous_slot,
	output logic                    switched,
	output logic [REAP_W-1:0]       reaped_count,
	output logic                    status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [PRIO_W-1:0]  init_priority
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MOD  = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_SEL  = 7'b0001000,
		ST_RCHG = 7'b0010000,
		ST_REAP = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [TASK_SLOTS-1:0]  valid_q, zombie_q, written_q;
	logic                   p0_cfg_q;
	logic [PRIO_W-1:0]      init_prio_q;
	logic [SLOT_W-1:0]      cur_q, prev_q;
	logic [2:0]             cmd_q;
	logic [REAP_W-1:0]      reaped_q;
	logic                   status_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   rd_s1;
	logic [SLOT_W-1:0]      idx_s1;
	logic                   found_q, anyp_q;
	logic [SLOT_W-1:0]      best_q;
	logic [CNT_W-1:0]       bc_q;

	ram_wr_t                wr;
	logic [SLOT_W-1:0]      raddr;
	entry_t                 rdata;
	entry_t                 cur_e, scan_e, mod_e;
	logic [CNT_W-1:0]       new_cnt;
	logic                   resched;
	logic                   run_s1, last_s1, take;
	logic [CNT_W-1:0]       pick_cnt;
	logic                   in_xfer, out_load;

	cpts_table_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid || out_ready);
	assign raddr     = (state_q == ST_IDLE) ? cur_q : idx_q[SLOT_W-1:0];

	assign cur_e  = entry_view(rdata, written_q[cur_q], p0_cfg_q && (cur_q == '0), init_prio_q);
	assign scan_e = entry_view(rdata, written_q[idx_s1], p0_cfg_q && (idx_s1 == '0),
		init_prio_q);
	assign run_s1  = valid_q[idx_s1] && !zombie_q[idx_s1];
	assign last_s1 = rd_s1 && (idx_s1 == SLOT_W'(TASK_SLOTS - 1));
	assign pick_cnt = (state_q == ST_RCHG) ?
		({1'b0, scan_e.counter[CNT_W-1:1]} + CNT_W'(scan_e.prio)) : scan_e.counter;
	assign take = rd_s1 && run_s1 && (!found_q || pick_cnt > bc_q);

	always_comb begin
		mod_e   = cur_e;
		new_cnt = (cur_e.counter != '0) ? cur_e.counter - 1'b1 : '0;
		resched = 1'b0;
		unique case (cmd_q)
			CMD_TICK: begin
				mod_e.counter = new_cnt;
				resched = (new_cnt == '0) && (cur_e.depth == '0);
			end
			CMD_YIELD, CMD_EXIT: begin
				mod_e.counter = '0;
				resched = 1'b1;
			end
			CMD_PDIS: begin
				if (cur_e.depth != DEPTH_MAX) begin
					mod_e.depth = cur_e.depth + 1'b1;
				end
			end
			CMD_PEN: begin
				if (cur_e.depth != '0) begin
					mod_e.depth = cur_e.depth - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr = '0;
		unique case (state_q)
			ST_IDLE: begin
				wr.en   = in_xfer && (command == CMD_INSTALL);
				wr.addr = slot;
				wr.data = '{counter: counter_value, prio: priority_req, depth: '0};
			end
			ST_MOD: begin
				wr.en   = 1'b1;
				wr.addr = cur_q;
				wr.data = mod_e;
			end
			ST_RCHG: begin
				wr.en   = rd_s1 && valid_q[idx_s1];
				wr.addr = idx_s1;
				wr.data = '{counter: pick_cnt, prio: scan_e.prio, depth: scan_e.depth};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= TASK_SLOTS'(1);
			zombie_q    <= '0;
			written_q   <= '0;
			p0_cfg_q    <= 1'b1;
			init_prio_q <= PRIO_W'(1);
			cur_q       <= '0;
			prev_q      <= '0;
			cmd_q       <= '0;
			reaped_q    <= '0;
			status_q    <= 1'b0;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			anyp_q      <= 1'b0;
			best_q      <= '0;
			bc_q        <= '0;
			out_valid     <= 1'b0;
			current_slot  <= '0;
			previous_slot <= '0;
			switched      <= 1'b0;
			reaped_count  <= '0;
			status        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				init_prio_q <= init_priority;
				p0_cfg_q    <= 1'b1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			rd_s1  <= ((state_q == ST_SCAN) || (state_q == ST_RCHG)) && !idx_q[IDX_W-1];
			idx_s1 <= idx_q[SLOT_W-1:0];
			if (take) begin
				found_q <= 1'b1;
				best_q  <= idx_s1;
				bc_q    <= pick_cnt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cmd_q    <= command;
						prev_q   <= cur_q;
						reaped_q <= '0;
						status_q <= 1'b0;
						idx_q    <= '0;
						priority case (command)
							CMD_INSTALL: begin
								valid_q[slot]  <= 1'b1;
								zombie_q[slot] <= 1'b0;
								if (slot == '0) begin
									p0_cfg_q <= 1'b0;
								end
								state_q <= ST_DONE;
							end
							CMD_REAP: state_q <= ST_REAP;
							CMD_TICK, CMD_YIELD, CMD_EXIT, CMD_PDIS, CMD_PEN:
								state_q <= ST_MOD;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MOD: begin
					if (cmd_q == CMD_EXIT) begin
						zombie_q[cur_q] <= 1'b1;
					end
					found_q <= 1'b0;
					anyp_q  <= 1'b0;
					idx_q   <= '0;
					state_q <= resched ? ST_SCAN : ST_DONE;
				end
				ST_SCAN, ST_RCHG: begin
					if (!idx_q[IDX_W-1]) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_s1 && run_s1 && (scan_e.prio != '0)) begin
						anyp_q <= 1'b1;
					end
					if (last_s1) begin
						if (state_q == ST_SCAN) begin
							state_q <= ST_SEL;
						end else begin
							cur_q   <= take ? idx_s1 : best_q;
							state_q <= ST_DONE;
						end
					end
				end
				ST_SEL: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (!found_q) begin
						cur_q   <= '0;
						state_q <= ST_DONE;
					end else if (bc_q != '0) begin
						cur_q   <= best_q;
						state_q <= ST_DONE;
					end else if (!anyp_q) begin
						cur_q    <= '0;
						status_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_RCHG;
					end
				end
				ST_REAP: begin
					if (valid_q[idx_q[SLOT_W-1:0]] && zombie_q[idx_q[SLOT_W-1:0]]) begin
						valid_q[idx_q[SLOT_W-1:0]]  <= 1'b0;
						zombie_q[idx_q[SLOT_W-1:0]] <= 1'b0;
						reaped_q <= reaped_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q[SLOT_W-1:0] == SLOT_W'(TASK_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid     <= 1'b1;
						current_slot  <= cur_q;
						previous_slot <= prev_q;
						switched      <= (cur_q != prev_q);
						reaped_count  <= reaped_q;
						status        <= status_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CPTS_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state_q != ST_IDLE)
	`CPTS_ASSERT_NOW(a_fallback_slot_zero, (state_q == ST_DONE) && status_q, cur_q == '0)
	`CPTS_ASSERT_NOW(a_reap_count_only_reap, reaped_q != '0, cmd_q == CMD_REAP)
	`CPTS_ASSERT_NOW(a_recharge_valid_only, wr.en && (state_q == ST_RCHG), valid_q[wr.addr])
endmodule
`default_nettype wire

// ===== design/cpts_table_ram.sv =====
// -----------------------------------------------------------------------------
// cpts_table_ram
// Task table storage: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module cpts_table_ram import cpts_pkg::*; (
	input  wire logic              clk,
	input  wire ram_wr_t           wr,
	input  wire logic [SLOT_W-1:0] raddr,
	output entry_t                 rdata
);
	entry_t mem [TASK_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
